### sv/rtsr_pkg.sv
// rtsr_pkg: item types, pipeline structs and constants of the rtp timestamp rewriter
// used by every module of the block; depends on nothing
package rtsr_pkg;

    // one rtp header as it arrives
    typedef struct packed {
        logic        kind;
        logic [31:0] ssrc_in;
        logic [31:0] timestamp_in;
        logic [15:0] seq_in;
        logic [6:0]  payload_type;
        logic [62:0] now_us;
        logic        resume;
    } t_in_item;

    // one rewritten header
    typedef struct packed {
        logic [31:0] timestamp_out;
        logic [15:0] seq_out;
        logic        ssrc_switched;
    } t_out_item;

    // header fields the state stage still needs
    typedef struct packed {
        logic        kind;
        logic [31:0] ssrc;
        logic [31:0] ts;
        logic [15:0] seq;
        logic        resume;
    } t_hdr;

    // item inside the elapsed-time divider
    typedef struct packed {
        t_hdr        hdr;
        logic [63:0] dvd;      // dividend digits still to go, msb first
        logic [6:0]  rem;      // running remainder of the divide by 125
        logic [31:0] quo;      // low quotient bits so far
        logic        qnz;      // some quotient digit was nonzero
        logic [2:0]  low3;     // elapsed bits below the divide by 8
        logic [6:0]  khz;      // clock rate in ticks per ms
        logic        has_prev; // channel has seen an earlier packet
    } t_div;

    // item between the two tick stages
    typedef struct packed {
        t_hdr        hdr;
        logic [31:0] qk;       // whole milliseconds times rate, mod 2^32
        logic [16:0] y;        // leftover microseconds times rate
        logic        qnz;
        logic        has_prev;
    } t_tk;

    // item entering the state stage
    typedef struct packed {
        t_hdr        hdr;
        logic [31:0] adv;      // ticks to advance on an ssrc switch
    } t_adv;

    // resume gap after reset
    localparam logic [15:0] GAP_RESET = 16'd2000;

    // clock rates in ticks per ms
    localparam logic [6:0] KHZ_VIDEO  = 7'd90;
    localparam logic [6:0] KHZ_WIDE   = 7'd48;
    localparam logic [6:0] KHZ_NARROW = 7'd8;

    // payload types on the 8 kHz clock
    localparam logic [6:0] PT_PCMU = 7'd0;
    localparam logic [6:0] PT_PCMA = 7'd8;
    localparam logic [6:0] PT_G722 = 7'd9;

    // microseconds per ms, split into a shift by 3 and a divide by 125
    localparam int unsigned US_PER_MS = 1000;
    localparam logic [7:0]  DIV_LO    = 8'(US_PER_MS / 8);
    localparam int unsigned LO_SHIFT  = 22;
    localparam logic [15:0] RECIP_LO  = 16'((1 << LO_SHIFT) / (US_PER_MS / 8));
    localparam int unsigned MS_SHIFT  = 27;
    localparam logic [17:0] RECIP_MS  = 18'((1 << MS_SHIFT) / US_PER_MS);
    localparam logic [16:0] MS_CONST  = 17'(US_PER_MS);

    // divider layout: eight digits of eight bits
    localparam int unsigned DIV_STAGES = 8;
    localparam int unsigned N_STG      = DIV_STAGES + 5;

endpackage

### sv/rtsr_front.sv
// rtsr_front: input register and elapsed-time stage of the rtp timestamp rewriter
// keeps the last arrival time per channel; depends on rtsr_pkg
module rtsr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  rtsr_pkg::t_in_item i_item,
    input  logic              i_en0,
    input  logic              i_en1,
    output logic              o_vld0,
    output logic              o_vld1,
    output rtsr_pkg::t_div    o_div
);

    logic               r_vld0;
    rtsr_pkg::t_in_item r_item;
    logic               r_vld1;
    rtsr_pkg::t_div     r_div;
    logic [62:0]        r_last_time [2];

    logic [62:0]        last_t;
    logic [62:0]        elapsed;
    logic [6:0]         khz;
    rtsr_pkg::t_div     n_div;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (i_en0) begin
            r_vld0 <= i_in_valid;
        end
        if (i_en0) begin
            r_item <= i_item;
        end
    end

    // elapsed time, clamped at zero when time runs backwards
    always_comb begin
        last_t  = r_last_time[r_item.kind];
        elapsed = (r_item.now_us >= last_t) ? (r_item.now_us - last_t) : 63'd0;
        if (r_item.kind) begin
            khz = rtsr_pkg::KHZ_VIDEO;
        end else if (r_item.payload_type == rtsr_pkg::PT_PCMU ||
                     r_item.payload_type == rtsr_pkg::PT_PCMA ||
                     r_item.payload_type == rtsr_pkg::PT_G722) begin
            khz = rtsr_pkg::KHZ_NARROW;
        end else begin
            khz = rtsr_pkg::KHZ_WIDE;
        end
        n_div.hdr.kind   = r_item.kind;
        n_div.hdr.ssrc   = r_item.ssrc_in;
        n_div.hdr.ts     = r_item.timestamp_in;
        n_div.hdr.seq    = r_item.seq_in;
        n_div.hdr.resume = r_item.resume;
        n_div.dvd        = {4'd0, elapsed[62:3]};
        n_div.rem        = 7'd0;
        n_div.quo        = 32'd0;
        n_div.qnz        = 1'b0;
        n_div.low3       = elapsed[2:0];
        n_div.khz        = khz;
        n_div.has_prev   = (last_t != 63'd0);
    end

    // elapsed stage and arrival-time tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1         <= 1'b0;
            r_last_time[0] <= 63'd0;
            r_last_time[1] <= 63'd0;
        end else if (i_en1) begin
            r_vld1 <= r_vld0;
            if (r_vld0) begin
                r_last_time[r_item.kind] <= r_item.now_us;
            end
        end
        if (i_en1) begin
            r_div <= n_div;
        end
    end

    assign o_vld0 = r_vld0;
    assign o_vld1 = r_vld1;
    assign o_div  = r_div;

endmodule

### sv/rtsr_div_stage.sv
// rtsr_div_stage: one eight-bit digit of the elapsed-time divide by 125
// reciprocal estimate with one correction step; depends on rtsr_pkg
module rtsr_div_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  rtsr_pkg::t_div i_div,
    output logic           o_vld,
    output rtsr_pkg::t_div o_div
);

    logic           r_vld;
    rtsr_pkg::t_div r_div;

    logic [14:0]    x;
    logic [29:0]    prod;
    logic [7:0]     qe;
    logic [16:0]    back;
    logic [14:0]    rr;
    logic [7:0]     qd;
    logic [6:0]     rn;
    rtsr_pkg::t_div n_div;

    // quotient digit: estimate low by at most one, then fix
    always_comb begin
        x    = {i_div.rem, i_div.dvd[63:56]};
        prod = 30'(x) * 30'(rtsr_pkg::RECIP_LO);
        qe   = prod[29:22];
        back = 17'(qe) * 17'(rtsr_pkg::DIV_LO);
        rr   = x - back[14:0];
        if (rr >= 15'(rtsr_pkg::DIV_LO)) begin
            qd = qe + 8'd1;
            rn = 7'(rr - 15'(rtsr_pkg::DIV_LO));
        end else begin
            qd = qe;
            rn = rr[6:0];
        end
        n_div     = i_div;
        n_div.dvd = {i_div.dvd[55:0], 8'd0};
        n_div.rem = rn;
        n_div.quo = {i_div.quo[23:0], qd};
        n_div.qnz = i_div.qnz | (qd != 8'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_vld = r_vld;
    assign o_div = r_div;

endmodule

### sv/rtsr_ticks.sv
// rtsr_ticks: turns elapsed ms and leftover us into timestamp ticks, two stages
// applies the one-tick minimum and the no-earlier-packet case; depends on rtsr_pkg
module rtsr_ticks (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en_a,
    input  logic           i_en_b,
    input  logic           i_vld,
    input  rtsr_pkg::t_div i_div,
    output logic           o_vld_a,
    output logic           o_vld_b,
    output rtsr_pkg::t_adv o_adv
);

    logic           r_vld_a;
    rtsr_pkg::t_tk  r_tk;
    logic           r_vld_b;
    rtsr_pkg::t_adv r_adv;

    rtsr_pkg::t_tk  n_tk;
    logic [33:0]    prod;
    logic [6:0]     est;
    logic [16:0]    back;
    logic [16:0]    rr;
    logic [6:0]     frac;
    logic [31:0]    ticks;
    rtsr_pkg::t_adv n_adv;

    // products by the clock rate
    always_comb begin
        n_tk.hdr      = i_div.hdr;
        n_tk.qk       = i_div.quo * {25'd0, i_div.khz};
        n_tk.y        = 17'({i_div.rem, i_div.low3}) * 17'(i_div.khz);
        n_tk.qnz      = i_div.qnz;
        n_tk.has_prev = i_div.has_prev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else if (i_en_a) begin
            r_vld_a <= i_vld;
        end
        if (i_en_a) begin
            r_tk <= n_tk;
        end
    end

    // leftover part divided by 1000, then the tick count
    always_comb begin
        prod = 34'(r_tk.y) * 34'(rtsr_pkg::RECIP_MS);
        est  = prod[33:27];
        back = 17'(est) * rtsr_pkg::MS_CONST;
        rr   = r_tk.y - back;
        frac = (rr >= rtsr_pkg::MS_CONST) ? (est + 7'd1) : est;
        ticks = r_tk.qk + 32'(frac);
        if (!r_tk.qnz && frac == 7'd0) begin
            ticks = 32'd1;
        end
        n_adv.hdr = r_tk.hdr;
        n_adv.adv = r_tk.has_prev ? ticks : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= 1'b0;
        end else if (i_en_b) begin
            r_vld_b <= r_vld_a;
        end
        if (i_en_b) begin
            r_adv <= n_adv;
        end
    end

    assign o_vld_a = r_vld_a;
    assign o_vld_b = r_vld_b;
    assign o_adv   = r_adv;

endmodule

### sv/rtsr_state.sv
// rtsr_state: per-channel rebasing state and the result register
// ssrc switch, resume and output arithmetic in one pass; depends on rtsr_pkg
module rtsr_state (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  rtsr_pkg::t_adv      i_adv,
    input  logic [15:0]         i_gap,
    output logic                o_vld,
    output rtsr_pkg::t_out_item o_item
);

    logic                r_vld;
    rtsr_pkg::t_out_item r_item;
    logic [31:0]         r_last_ssrc    [2];
    logic [31:0]         r_base_ts      [2];
    logic [31:0]         r_base_ts_prev [2];
    logic [15:0]         r_base_seq     [2];
    logic [15:0]         r_base_seq_prev[2];
    logic [31:0]         r_last_ts      [2];
    logic [15:0]         r_last_seq     [2];

    logic                c;
    logic                sw;
    logic [31:0]         n_base_ts;
    logic [31:0]         n_base_ts_prev;
    logic [15:0]         n_base_seq;
    logic [15:0]         n_base_seq_prev;
    logic [31:0]         lts_adv;
    logic [31:0]         n_ts;
    logic [15:0]         n_seq;

    // switch steps first, then resume steps, then the rewrite
    always_comb begin
        c               = i_adv.hdr.kind;
        sw              = (i_adv.hdr.ssrc != r_last_ssrc[c]);
        n_base_ts       = r_base_ts[c];
        n_base_ts_prev  = r_base_ts_prev[c];
        n_base_seq      = r_base_seq[c];
        n_base_seq_prev = r_base_seq_prev[c];
        lts_adv         = r_last_ts[c] + i_adv.adv;
        if (sw) begin
            n_base_ts       = i_adv.hdr.ts;
            n_base_ts_prev  = lts_adv;
            n_base_seq      = i_adv.hdr.seq;
            n_base_seq_prev = r_last_seq[c];
        end else begin
            lts_adv = r_last_ts[c];
        end
        if (i_adv.hdr.resume) begin
            n_base_seq      = i_adv.hdr.seq;
            n_base_seq_prev = r_last_seq[c];
            n_base_ts_prev  = lts_adv + {16'd0, i_gap};
        end
        n_ts  = i_adv.hdr.ts - n_base_ts + n_base_ts_prev;
        n_seq = i_adv.hdr.seq - n_base_seq + n_base_seq_prev + 16'd1;
    end

    // state update and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            for (int k = 0; k < 2; k++) begin
                r_last_ssrc[k]     <= 32'd0;
                r_base_ts[k]       <= 32'd0;
                r_base_ts_prev[k]  <= 32'd0;
                r_base_seq[k]      <= 16'd0;
                r_base_seq_prev[k] <= 16'd0;
                r_last_ts[k]       <= 32'd0;
                r_last_seq[k]      <= 16'd0;
            end
        end else if (i_en) begin
            r_vld <= i_vld;
            if (i_vld) begin
                r_last_ssrc[c]     <= i_adv.hdr.ssrc;
                r_base_ts[c]       <= n_base_ts;
                r_base_ts_prev[c]  <= n_base_ts_prev;
                r_base_seq[c]      <= n_base_seq;
                r_base_seq_prev[c] <= n_base_seq_prev;
                r_last_ts[c]       <= n_ts;
                r_last_seq[c]      <= n_seq;
            end
        end
        if (i_en) begin
            r_item.timestamp_out <= n_ts;
            r_item.seq_out       <= n_seq;
            r_item.ssrc_switched <= sw;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

### sv/rtp_seq_timestamp_rewriter.sv
// rtp_seq_timestamp_rewriter: top level of the two-channel rtp timestamp rewriter
// depends on rtsr_pkg, rtsr_front, rtsr_div_stage, rtsr_ticks, rtsr_state
//
// usage:
// - input channel i_in_valid / o_in_ready / i_in_data carries one rtp header item
// - output channel o_out_valid / i_out_ready / o_out_data returns one rewritten item
//   per input item, in order
// - config channel i_cfg_valid / o_cfg_ready / i_cfg_data writes resume_gap; always
//   ready, write only while no item is in flight
// - stages: the input register loads at the accepting edge, then the elapsed-time
//   stage, eight digit stages of the divide by 125, two tick stages and the state
//   stage that loads the result register
// - throughput: one item per cycle while the receiver does not stall; only the
//   per-channel state update and the per-channel arrival time sit in loops, each
//   one register stage deep
// - when the receiver stalls, items close up into empty stages; o_in_ready drops
//   only once every stage holds an item and the result waits
// - synchronous reset clears all per-channel state, the arrival times and the
//   pipeline valid bits, and sets resume_gap to 2000
module rtp_seq_timestamp_rewriter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rtsr_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rtsr_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);

    localparam int unsigned NS = rtsr_pkg::N_STG;
    localparam int unsigned ND = rtsr_pkg::DIV_STAGES;

    logic [15:0]    r_gap;
    wire  [NS-1:0]  w_vld;
    logic [NS-1:0]  en;
    rtsr_pkg::t_div div_d [ND+1];
    rtsr_pkg::t_adv adv_d;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= rtsr_pkg::GAP_RESET;
        end else if (i_cfg_valid) begin
            r_gap <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    // a stage loads unless it and every stage after it is full and the result waits
    always_comb begin
        logic [NS-1:0] low;
        for (int k = 0; k < NS; k++) begin
            low   = (NS'(1) << k) - NS'(1);
            en[k] = i_out_ready || !(&(w_vld | low));
        end
    end
    assign o_in_ready = en[0];

    rtsr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_item     (i_in_data),
        .i_en0      (en[0]),
        .i_en1      (en[1]),
        .o_vld0     (w_vld[0]),
        .o_vld1     (w_vld[1]),
        .o_div      (div_d[0])
    );

    // divide by 125, one digit per stage
    for (genvar g = 0; g < ND; g++) begin : g_div
        rtsr_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en[g+2]),
            .i_vld   (w_vld[g+1]),
            .i_div   (div_d[g]),
            .o_vld   (w_vld[g+2]),
            .o_div   (div_d[g+1])
        );
    end

    rtsr_ticks u_ticks (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en_a  (en[ND+2]),
        .i_en_b  (en[ND+3]),
        .i_vld   (w_vld[ND+1]),
        .i_div   (div_d[ND]),
        .o_vld_a (w_vld[ND+2]),
        .o_vld_b (w_vld[ND+3]),
        .o_adv   (adv_d)
    );

    rtsr_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en[ND+4]),
        .i_vld   (w_vld[ND+3]),
        .i_adv   (adv_d),
        .i_gap   (r_gap),
        .o_vld   (w_vld[ND+4]),
        .o_item  (o_out_data)
    );

    assign o_out_valid = w_vld[ND+4];

endmodule

### sv/rtsr_checker.sv
// rtsr_checker: port-level checks of the rtp timestamp rewriter, bound to the top
// depends on rtsr_pkg and rtp_seq_timestamp_rewriter
module rtsr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input rtsr_pkg::t_out_item o_out_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // input backpressure only when a result is stuck at the output
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output backpressure");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown after reset");

endmodule

bind rtp_seq_timestamp_rewriter rtsr_checker u_rtsr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

### test/tb_rtp_seq_timestamp_rewriter.sv
// tb_rtp_seq_timestamp_rewriter: self-checking bench for the rtp timestamp rewriter,
// directed headers then random streams, checked against a per-channel rewrite predictor
// depends on rtsr_pkg and rtp_seq_timestamp_rewriter
module tb_rtp_seq_timestamp_rewriter;
    import rtsr_pkg::*;

    localparam int unsigned PIPE_LAT    = 12;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // headers waiting to be sent and rewrites waiting to come back
    t_in_item    hdr_queue[$];
    t_out_item   expected_rewrites[$];

    int unsigned cycle_cnt = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned in_gap;
    int unsigned out_stall;
    logic        steady;

    // predictor copy of the per-channel state and the resume gap
    logic [15:0] gap_model;
    logic [31:0] ch_ssrc[2];
    logic [31:0] ch_base_ts[2];
    logic [31:0] ch_base_ts_prev[2];
    logic [15:0] ch_base_seq[2];
    logic [15:0] ch_base_seq_prev[2];
    logic [31:0] ch_ts[2];
    logic [15:0] ch_seq[2];
    logic [63:0] ch_time[2];

    // random stream generator state
    logic [31:0] gen_ssrc[2];
    logic [31:0] gen_ts[2];
    logic [15:0] gen_seq[2];
    logic [62:0] gen_now;

    rtp_seq_timestamp_rewriter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // watchdog
    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("** rtp_seq_timestamp_rewriter: FAILED **");
        $finish;
    end

    // rewrite one header and update the channel state
    function automatic t_out_item rewrite_header(input t_in_item h);
        int unsigned c;
        logic [63:0] elapsed;
        logic [71:0] ticks;
        logic [6:0]  khz;
        t_out_item   r;
        c = h.kind;
        r.ssrc_switched = 1'b0;
        if (h.ssrc_in != ch_ssrc[c]) begin
            r.ssrc_switched = 1'b1;
            ch_ssrc[c] = h.ssrc_in;
            ch_base_ts_prev[c] = ch_ts[c];
            ch_base_ts[c] = h.timestamp_in;
            ch_base_seq_prev[c] = ch_seq[c];
            ch_base_seq[c] = h.seq_in;
            // advance by elapsed arrival time when the channel has history
            if (ch_time[c] != 64'd0) begin
                if ({1'b0, h.now_us} >= ch_time[c])
                    elapsed = {1'b0, h.now_us} - ch_time[c];
                else
                    elapsed = 64'd0;
                if (h.kind)
                    khz = KHZ_VIDEO;
                else if (h.payload_type == PT_PCMU || h.payload_type == PT_PCMA ||
                         h.payload_type == PT_G722)
                    khz = KHZ_NARROW;
                else
                    khz = KHZ_WIDE;
                ticks = ({8'd0, elapsed} * 72'(khz)) / 72'(US_PER_MS);
                if (ticks == 72'd0)
                    ticks = 72'd1;
                ch_base_ts_prev[c] = ch_base_ts_prev[c] + ticks[31:0];
                ch_ts[c] = ch_ts[c] + ticks[31:0];
            end
        end
        if (h.resume) begin
            ch_base_seq_prev[c] = ch_seq[c];
            ch_base_seq[c] = h.seq_in;
            ch_base_ts_prev[c] = ch_ts[c] + 32'(gap_model);
        end
        ch_ts[c] = (h.timestamp_in - ch_base_ts[c]) + ch_base_ts_prev[c];
        ch_seq[c] = h.seq_in - ch_base_seq[c] + ch_base_seq_prev[c] + 16'd1;
        ch_time[c] = {1'b0, h.now_us};
        r.timestamp_out = ch_ts[c];
        r.seq_out = ch_seq[c];
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (mismatch_cnt < 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
        mismatch_cnt++;
    endtask

    task automatic push_hdr(input logic k, input logic [31:0] s, input logic [31:0] t,
                            input logic [15:0] q, input logic [6:0] p,
                            input logic [62:0] n, input logic res);
        t_in_item h;
        h.kind = k;
        h.ssrc_in = s;
        h.timestamp_in = t;
        h.seq_in = q;
        h.payload_type = p;
        h.now_us = n;
        h.resume = res;
        hdr_queue.push_back(h);
    endtask

    // mostly coherent per-channel streams, some noise headers
    task automatic queue_random_headers(input int count);
        int unsigned c;
        int unsigned roll;
        t_in_item    h;
        for (int i = 0; i < count; i++) begin
            c = $urandom_range(0, 1);
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                h.kind = c[0];
                h.ssrc_in = $urandom;
                h.timestamp_in = $urandom;
                h.seq_in = 16'($urandom);
                h.payload_type = 7'($urandom);
                h.now_us = 63'({$urandom, $urandom});
                h.resume = 1'($urandom);
            end else begin
                // new source with its own timestamp and sequence origin
                if (roll < 22) begin
                    gen_ssrc[c] = $urandom;
                    gen_ts[c] = $urandom;
                    gen_seq[c] = 16'($urandom);
                end
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    gen_now = 63'({$urandom, $urandom});
                else
                    gen_now = gen_now + 63'($urandom_range(1, 60000));
                h.now_us = gen_now;
                if (roll >= 3 && roll < 7)
                    h.now_us = gen_now - 63'($urandom_range(1, 30000));
                else if (roll >= 7 && roll < 9)
                    h.now_us = '0;
                gen_ts[c] = gen_ts[c] + (c ? 32'd3000 : 32'd960);
                if ($urandom_range(0, 9) == 0)
                    gen_seq[c] = gen_seq[c] + 16'($urandom_range(2, 20));
                else
                    gen_seq[c] = gen_seq[c] + 16'd1;
                h.kind = c[0];
                h.ssrc_in = gen_ssrc[c];
                h.timestamp_in = gen_ts[c];
                h.seq_in = gen_seq[c];
                case ($urandom_range(0, 4))
                    0: h.payload_type = PT_PCMU;
                    1: h.payload_type = PT_PCMA;
                    2: h.payload_type = PT_G722;
                    default: h.payload_type = 7'($urandom);
                endcase
                h.resume = ($urandom_range(0, 99) < 8);
            end
            hdr_queue.push_back(h);
        end
    endtask

    // wait until every header is sent and every rewrite is back, then let the pipe drain
    // checked between edges so the driver's updates of the same edge are settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (hdr_queue.size() != 0 || in_valid || expected_rewrites.size() != 0);
        repeat (PIPE_LAT + 8) @(posedge i_clk);
    endtask

    task automatic write_gap(input logic [15:0] v);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        gap_model = v;
    endtask

    // header driver
    always @(posedge i_clk) begin
        logic fire;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end else begin
            fire = in_valid && in_ready;
            if (fire)
                expected_rewrites.push_back(rewrite_header(in_data));
            if (in_valid && !fire) begin
                // hold the item until it is taken
            end else if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end else if (hdr_queue.size() != 0) begin
                in_data <= hdr_queue.pop_front();
                in_valid <= 1'b1;
                if (!steady && $urandom_range(0, 99) < 15)
                    in_gap <= $urandom_range(1, 6);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_rewrites.size() == 0) begin
                    flag_mismatch("unexpected result, timestamp_out", '0,
                                  out_data.timestamp_out);
                end else begin
                    want = expected_rewrites.pop_front();
                    if (out_data.timestamp_out !== want.timestamp_out)
                        flag_mismatch("timestamp_out", want.timestamp_out,
                                      out_data.timestamp_out);
                    if (out_data.seq_out !== want.seq_out)
                        flag_mismatch("seq_out", 32'(want.seq_out), 32'(out_data.seq_out));
                    if (out_data.ssrc_switched !== want.ssrc_switched)
                        flag_mismatch("ssrc_switched", 32'(want.ssrc_switched),
                                      32'(out_data.ssrc_switched));
                end
            end
            if (out_stall > 0) begin
                out_stall <= out_stall - 1;
                out_ready <= 1'b0;
            end else if (!steady && $urandom_range(0, 99) < 12) begin
                out_stall <= $urandom_range(0, 5);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // reset, phases and end of run
    initial begin
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        steady = 1'b0;
        in_gap = 0;
        out_stall = 0;
        gap_model = GAP_RESET;
        for (int c = 0; c < 2; c++) begin
            ch_ssrc[c] = '0;
            ch_base_ts[c] = '0;
            ch_base_ts_prev[c] = '0;
            ch_base_seq[c] = '0;
            ch_base_seq_prev[c] = '0;
            ch_ts[c] = '0;
            ch_seq[c] = '0;
            ch_time[c] = '0;
            gen_ssrc[c] = $urandom;
            gen_ts[c] = $urandom;
            gen_seq[c] = 16'($urandom);
        end
        gen_now = 63'd1000000;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first packet with ssrc zero is no switch
        push_hdr(1'b0, 32'd0, 32'd1000, 16'd10, PT_PCMU, 63'd1000, 1'b0);
        push_hdr(1'b0, 32'd0, 32'd1160, 16'd11, PT_PCMU, 63'd21000, 1'b0);
        // switches on each audio clock rate
        push_hdr(1'b0, 32'hFFFF_FFFF, 32'h8000_0000, 16'h8000, PT_PCMA, 63'd41000, 1'b0);
        push_hdr(1'b0, 32'd1, 32'd5, 16'd3, PT_G722, 63'd61000, 1'b0);
        push_hdr(1'b0, 32'd2, 32'd77, 16'd9, 7'd111, 63'd81000, 1'b0);
        // video first packet, then timestamp and sequence wrap
        push_hdr(1'b1, 32'h1234_5678, 32'hFFFF_FFF0, 16'hFFFF, 7'd96, 63'd5000, 1'b0);
        push_hdr(1'b1, 32'h1234_5678, 32'h0000_0010, 16'h0000, 7'd96, 63'd38000, 1'b0);
        // arrival time going backwards gives one tick
        push_hdr(1'b1, 32'hA5A5_5A5A, 32'd300, 16'd40, 7'd96, 63'd100, 1'b0);
        // resume alone, then resume together with a switch
        push_hdr(1'b1, 32'hA5A5_5A5A, 32'd3300, 16'd41, 7'd96, 63'd33000, 1'b1);
        push_hdr(1'b1, 32'h0F0F_0F0F, 32'd9, 16'd500, 7'd97, 63'd66000, 1'b1);
        // arrival time zero, then a switch that sees no history
        push_hdr(1'b0, 32'd2, 32'd1037, 16'd10, 7'd111, 63'd0, 1'b0);
        push_hdr(1'b0, 32'd3, 32'd4000, 16'd20, 7'd111, 63'd90000, 1'b0);
        // huge elapsed time, then zero elapsed
        push_hdr(1'b1, 32'd7, 32'd1, 16'd1, 7'd96, 63'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        push_hdr(1'b1, 32'd8, 32'd2, 16'd2, 7'd96, 63'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        // elapsed below one tick on the narrow clock, then a resume
        push_hdr(1'b0, 32'd4, 32'd5000, 16'd30, PT_PCMU, 63'd90001, 1'b0);
        push_hdr(1'b0, 32'd4, 32'd5160, 16'd31, PT_PCMU, 63'd110001, 1'b1);
        // every field at its top, then every field at zero
        push_hdr(1'b1, '1, '1, '1, '1, '1, 1'b1);
        push_hdr(1'b0, '0, '0, '0, '0, '0, 1'b0);
        wait_idle();

        // random streams under several resume gaps
        write_gap(16'd0);
        queue_random_headers(130);
        wait_idle();
        write_gap(16'hFFFF);
        queue_random_headers(130);
        wait_idle();
        write_gap(16'($urandom));
        queue_random_headers(130);
        wait_idle();

        // last part runs without idling
        write_gap(16'd1);
        steady = 1'b1;
        queue_random_headers(140);
        wait_idle();

        if (mismatch_cnt == 0)
            $display("** rtp_seq_timestamp_rewriter: PASSED **");
        else
            $display("** rtp_seq_timestamp_rewriter: FAILED **");
        $finish;
    end

endmodule

### files.f
sv/rtsr_pkg.sv
sv/rtsr_front.sv
sv/rtsr_div_stage.sv
sv/rtsr_ticks.sv
sv/rtsr_state.sv
sv/rtp_seq_timestamp_rewriter.sv
sv/rtsr_checker.sv
test/tb_rtp_seq_timestamp_rewriter.sv
